// ===== sv/i2cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbs_pkg: shared types and constants of the I2C master bit sequencer
// Command and phase words, phase opcodes and the controller/datapath links.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
    localparam int HOLD_W        = 8;
    localparam int CFG_INDEX_W   = 2;

    // command codes
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_HOLD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_SETUP = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_HOLD = 2'd2;

    localparam logic [HOLD_W-1:0] LONG_HOLD_RST  = 8'd5;
    localparam logic [HOLD_W-1:0] DATA_SETUP_RST = 8'd4;
    localparam logic [HOLD_W-1:0] SHORT_HOLD_RST = 8'd1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data_byte;
        logic              sda_in;
    } cmd_word_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic [HOLD_W-1:0] hold_us;
        logic              nack;
        logic              last;
    } phase_word_t;

    // one recipe per kind of line phase
    typedef enum logic [3:0] {
        OP_START_REL   = 4'd0,
        OP_START_HI    = 4'd1,
        OP_START_FALL  = 4'd2,
        OP_START_END   = 4'd3,
        OP_CLK_LOW     = 4'd4,
        OP_STOP_SETUP  = 4'd5,
        OP_STOP_HI     = 4'd6,
        OP_STOP_END    = 4'd7,
        OP_BIT_SETUP   = 4'd8,
        OP_BIT_HI      = 4'd9,
        OP_ACK_LOW     = 4'd10,
        OP_ACK_HI      = 4'd11
    } phase_op_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        phase_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
    } dp_status_t;

endpackage

// ===== sv/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer: expands I2C master commands into line phases
// The first phase word of a command passes the state register, then the phase register.
// Throughput: one phase word per cycle while the phase side does not stall; a
// byte write is 26 phases, set by the phase walk of the controller.
// Reset: lines low, long_hold 5, data_setup 4, short_hold 1, no word pending.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_write,
    input  logic [i2cbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [i2cbs_pkg::HOLD_W-1:0]       cfg_data,
    // command words
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  i2cbs_pkg::cmd_word_t               cmd,
    // phase words
    output logic                               phase_valid,
    input  logic                               phase_stall,
    output i2cbs_pkg::phase_word_t             phase
);
    import i2cbs_pkg::*;

    // The controller owns the command walk: it takes one command while idle,
    // then steps through the phases of that command, one per cycle whenever
    // the phase register is free or being drained. An unused command code is
    // taken and dropped without any phase.
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    i2cbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_kind  (cmd.kind),
        .cmd_stall (cmd_stall),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    // The datapath keeps the timing registers and the driven line levels,
    // captures the byte and the sampled acknowledge level on command load,
    // shifts the byte out MSB first and holds each phase word in an output
    // register. A stalled phase side holds that register, which halts the
    // phase walk and keeps the command side stalled until the walk ends.
    i2cbs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd_data_byte (cmd.data_byte),
        .cmd_sda_in    (cmd.sda_in),
        .dp_cmd        (dp_cmd),
        .dp_status     (dp_status),
        .phase_valid   (phase_valid),
        .phase_stall   (phase_stall),
        .phase         (phase)
    );

`ifndef SYNTHESIS
    // NACK is only ever reported on the final phase of a command.
    a_nack_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        phase_valid && phase.nack |-> phase.last)
        else $error("nack reported on a phase that is not the last");

    // A real command keeps the sequencer busy in the next cycle.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall &&
        (cmd.kind == KIND_START || cmd.kind == KIND_STOP || cmd.kind == KIND_WRITE)
        |=> cmd_stall)
        else $error("sequencer not busy after a command was taken");

    // An unused command code is dropped at once.
    a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall &&
        cmd.kind != KIND_START && cmd.kind != KIND_STOP && cmd.kind != KIND_WRITE
        |=> !cmd_stall)
        else $error("unused command code did not return to idle");
`endif

endmodule

// ===== sv/i2cbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cbs_ctrl: command sequencer
// Walks the phases of one command and tells the datapath which phase to emit.
// ----------------------------------------------------------------------------
module i2cbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic [1:0]           cmd_kind,
    output logic                 cmd_stall,
    output i2cbs_pkg::dp_cmd_t   dp_cmd,
    input  i2cbs_pkg::dp_status_t dp_status
);
    import i2cbs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_STOP  = 5'b00100,
        ST_BIT   = 5'b01000,
        ST_ACK   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           sub_reg, sub_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 accept;
    logic                 emit;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign emit      = (state_reg != ST_IDLE) && dp_status.slot_free;

    always_comb
    begin
        state_next   = state_reg;
        sub_next     = sub_reg;
        bit_cnt_next = bit_cnt_reg;
        dp_cmd.load  = accept;
        dp_cmd.emit  = emit;
        dp_cmd.op    = OP_CLK_LOW;
        unique case (state_reg)
            ST_IDLE:
            begin
                sub_next     = 2'd0;
                bit_cnt_next = '0;
                if (accept)
                begin
                    priority if (cmd_kind == KIND_START)
                        state_next = ST_START;
                    else if (cmd_kind == KIND_STOP)
                        state_next = ST_STOP;
                    else if (cmd_kind == KIND_WRITE)
                        state_next = ST_BIT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                unique case (sub_reg)
                    2'd0:    dp_cmd.op = OP_START_REL;
                    2'd1:    dp_cmd.op = OP_START_HI;
                    2'd2:    dp_cmd.op = OP_START_FALL;
                    default: dp_cmd.op = OP_START_END;
                endcase
                if (emit)
                begin
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg == 2'd3)
                        state_next = ST_IDLE;
                end
            end
            ST_STOP:
            begin
                unique case (sub_reg)
                    2'd0:    dp_cmd.op = OP_CLK_LOW;
                    2'd1:    dp_cmd.op = OP_STOP_SETUP;
                    2'd2:    dp_cmd.op = OP_STOP_HI;
                    default: dp_cmd.op = OP_STOP_END;
                endcase
                if (emit)
                begin
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg == 2'd3)
                        state_next = ST_IDLE;
                end
            end
            ST_BIT:
            begin
                unique case (sub_reg)
                    2'd0:    dp_cmd.op = OP_CLK_LOW;
                    2'd1:    dp_cmd.op = OP_BIT_SETUP;
                    default: dp_cmd.op = OP_BIT_HI;
                endcase
                if (emit)
                begin
                    if (sub_reg == 2'd2)
                    begin
                        sub_next     = 2'd0;
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        if (bit_cnt_reg == BIT_CNT_W'(BITS_PER_BYTE - 1))
                            state_next = ST_ACK;
                    end
                    else
                    begin
                        sub_next = sub_reg + 2'd1;
                    end
                end
            end
            ST_ACK:
            begin
                dp_cmd.op = (sub_reg == 2'd0) ? OP_ACK_LOW : OP_ACK_HI;
                if (emit)
                begin
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg != 2'd0)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sub_reg     <= 2'd0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            sub_reg     <= sub_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

endmodule

// ===== sv/i2cbs_dp.sv =====
// ----------------------------------------------------------------------------
// i2cbs_dp: line level datapath
// Holds timing registers, line levels, the byte shifter and the phase register.
// ----------------------------------------------------------------------------
module i2cbs_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [i2cbs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [i2cbs_pkg::HOLD_W-1:0]          cfg_data,
    input  logic [7:0]                            cmd_data_byte,
    input  logic                                  cmd_sda_in,
    input  i2cbs_pkg::dp_cmd_t                    dp_cmd,
    output i2cbs_pkg::dp_status_t                 dp_status,
    output logic                                  phase_valid,
    input  logic                                  phase_stall,
    output i2cbs_pkg::phase_word_t                phase
);
    import i2cbs_pkg::*;

    logic [HOLD_W-1:0] long_hold_reg, data_setup_reg, short_hold_reg;
    logic              scl_level_reg, sda_level_reg;
    logic [7:0]        byte_reg;
    logic              ack_reg;
    logic              phase_valid_reg, phase_valid_next;
    phase_word_t       phase_reg, phase_next;
    logic              bit_now;

    assign bit_now             = byte_reg[7];
    assign dp_status.slot_free = !phase_valid_reg || !phase_stall;
    assign phase_valid         = phase_valid_reg;
    assign phase               = phase_reg;

    always_comb
    begin
        phase_next      = '0;
        phase_next.scl  = 1'b0;
        phase_next.sda  = 1'b0;
        unique case (dp_cmd.op)
            OP_START_REL:
            begin
                phase_next.scl = scl_level_reg;
                phase_next.sda = 1'b1;
            end
            OP_START_HI:
            begin
                phase_next.scl     = 1'b1;
                phase_next.sda     = 1'b1;
                phase_next.hold_us = long_hold_reg;
            end
            OP_START_FALL:
            begin
                phase_next.scl     = 1'b1;
                phase_next.hold_us = long_hold_reg;
            end
            OP_START_END:
            begin
                phase_next.last = 1'b1;
            end
            OP_CLK_LOW:
            begin
                phase_next.sda     = sda_level_reg;
                phase_next.hold_us = short_hold_reg;
            end
            OP_STOP_SETUP:
            begin
                phase_next.hold_us = data_setup_reg;
            end
            OP_STOP_HI:
            begin
                phase_next.scl     = 1'b1;
                phase_next.hold_us = long_hold_reg;
            end
            OP_STOP_END:
            begin
                phase_next.scl     = 1'b1;
                phase_next.sda     = 1'b1;
                phase_next.hold_us = long_hold_reg;
                phase_next.last    = 1'b1;
            end
            OP_BIT_SETUP:
            begin
                phase_next.sda     = bit_now;
                phase_next.hold_us = data_setup_reg;
            end
            OP_BIT_HI:
            begin
                phase_next.scl     = 1'b1;
                phase_next.sda     = bit_now;
                phase_next.hold_us = long_hold_reg;
            end
            OP_ACK_LOW:
            begin
                phase_next.sda     = 1'b1;
                phase_next.hold_us = long_hold_reg;
            end
            OP_ACK_HI:
            begin
                phase_next.scl     = 1'b1;
                phase_next.sda     = 1'b1;
                phase_next.hold_us = long_hold_reg;
                phase_next.nack    = ack_reg;
                phase_next.last    = 1'b1;
            end
            default:
            begin
                phase_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.emit)
            phase_valid_next = 1'b1;
        else if (phase_stall)
            phase_valid_next = phase_valid_reg;
        else
            phase_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold_reg   <= LONG_HOLD_RST;
            data_setup_reg  <= DATA_SETUP_RST;
            short_hold_reg  <= SHORT_HOLD_RST;
            scl_level_reg   <= 1'b0;
            sda_level_reg   <= 1'b0;
            phase_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_LONG_HOLD)
                    long_hold_reg <= cfg_data;
                if (cfg_index == REG_DATA_SETUP)
                    data_setup_reg <= cfg_data;
                if (cfg_index == REG_SHORT_HOLD)
                    short_hold_reg <= cfg_data;
            end
            if (dp_cmd.emit)
            begin
                scl_level_reg <= phase_next.scl;
                sda_level_reg <= phase_next.sda;
            end
            phase_valid_reg <= phase_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            byte_reg <= cmd_data_byte;
            ack_reg  <= cmd_sda_in;
        end
        else if (dp_cmd.emit && dp_cmd.op == OP_BIT_HI)
        begin
            byte_reg <= {byte_reg[6:0], 1'b0};
        end
        if (dp_cmd.emit)
            phase_reg <= phase_next;
    end

endmodule
